### sv/mdp_pkg.sv
package mdp_pkg;

  // Width of every residue on the ports and in the datapath.
  localparam int unsigned ResWidth = 30;

  // The modulus, a prime just below two to the thirtieth.
  localparam logic [ResWidth-1:0] Prime = 30'd998244353;

  // Working set of the binary inversion loop.
  typedef struct packed {
    logic [ResWidth-1:0] u;
    logic [ResWidth-1:0] v;
    logic [ResWidth-1:0] x1;
    logic [ResWidth-1:0] x2;
  } mdp_regs_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } mdp_state_t;

endpackage

### sv/mdp_step.sv
// One step of the binary extended inversion. The invariants are
// x1 * divisor == numerator * u and x2 * divisor == numerator * v (mod prime).
// A step halves an even u or v, or subtracts the smaller from the larger.
module mdp_step import mdp_pkg::*; (
  input  mdp_regs_t           cur,
  output mdp_regs_t           nxt,
  output logic                fin,
  output logic [ResWidth-1:0] quo
);

  logic            u_odd;
  logic            v_odd;
  logic            u_ge_v;
  logic [ResWidth:0] half_src;
  logic [ResWidth:0] half_sum;
  logic [ResWidth:0] diff_r;
  logic [ResWidth:0] diff_x;
  logic [ResWidth:0] diff_xp;
  logic [ResWidth-1:0] sub_a;
  logic [ResWidth-1:0] sub_b;
  logic [ResWidth-1:0] xsub_a;
  logic [ResWidth-1:0] xsub_b;

  assign u_odd = cur.u[0];
  assign v_odd = cur.v[0];
  assign fin   = (cur.u == ResWidth'(1)) || (cur.v == ResWidth'(1));
  assign quo   = (cur.u == ResWidth'(1)) ? cur.x1 : cur.x2;

  // Halving of a coefficient: add the prime first when it is odd.
  assign half_src = u_odd ? {1'b0, cur.x2} : {1'b0, cur.x1};
  assign half_sum = half_src[0] ? (half_src + {1'b0, Prime}) : half_src;

  // Subtractors for the remainders and for the coefficients, shared by both directions.
  assign u_ge_v  = (cur.u >= cur.v);
  assign sub_a   = u_ge_v ? cur.u : cur.v;
  assign sub_b   = u_ge_v ? cur.v : cur.u;
  assign xsub_a  = u_ge_v ? cur.x1 : cur.x2;
  assign xsub_b  = u_ge_v ? cur.x2 : cur.x1;
  assign diff_r  = {1'b0, sub_a} - {1'b0, sub_b};
  assign diff_x  = {1'b0, xsub_a} - {1'b0, xsub_b};
  assign diff_xp = diff_x + {1'b0, Prime};

  // Pick the single operation for this step.
  always_comb begin
    nxt = cur;
    priority if (fin) begin
      nxt = cur;
    end else if (!u_odd) begin
      nxt.u  = cur.u >> 1;
      nxt.x1 = half_sum[ResWidth:1];
    end else if (!v_odd) begin
      nxt.v  = cur.v >> 1;
      nxt.x2 = half_sum[ResWidth:1];
    end else if (u_ge_v) begin
      nxt.u  = diff_r[ResWidth-1:0];
      nxt.x1 = diff_x[ResWidth] ? diff_xp[ResWidth-1:0] : diff_x[ResWidth-1:0];
    end else begin
      nxt.v  = diff_r[ResWidth-1:0];
      nxt.x2 = diff_x[ResWidth] ? diff_xp[ResWidth-1:0] : diff_x[ResWidth-1:0];
    end
  end

endmodule

### sv/modular_division_prime.sv
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+-------------------------------
// input    | divisor, numerator             | start high while busy low
// result   | quotient, not_invertible       | done high for one cycle
//
// An item is loaded into the working registers and then runs one halving or
// subtraction step of the binary inversion loop per cycle; with a single
// step unit, no new item is taken while the loop runs.
// A zero divisor gives its result in the cycle after the item is taken.
// Reset is synchronous and active high and returns the block to idle.
// The receiver cannot stall: each result is shown for exactly one cycle.
module modular_division_prime import mdp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [ResWidth-1:0] divisor,
  input  logic [ResWidth-1:0] numerator,
  output logic                done,
  output logic [ResWidth-1:0] quotient,
  output logic                not_invertible
);

  mdp_state_t          state;
  mdp_state_t          state_next;
  mdp_regs_t           regs;
  mdp_regs_t           step_nxt;
  logic                step_fin;
  logic [ResWidth-1:0] step_quo;
  logic [ResWidth-1:0] div_red;
  logic [ResWidth-1:0] num_red;
  logic                accept;
  logic                div_zero;

  // Operands below twice the prime need one conditional subtraction.
  assign div_red  = (divisor >= Prime) ? (divisor - Prime) : divisor;
  assign num_red  = (numerator >= Prime) ? (numerator - Prime) : numerator;
  assign div_zero = (div_red == '0);
  assign accept   = start && (state == ST_IDLE);

  mdp_step u_step (
    .cur (regs),
    .nxt (step_nxt),
    .fin (step_fin),
    .quo (step_quo)
  );

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && !div_zero) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (step_fin) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    unique case (state)
      ST_IDLE: busy = 1'b0;
      ST_RUN:  busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (accept && div_zero) || ((state == ST_RUN) && step_fin);
    end
  end

  // Working registers: load on an accepted item, then step.
  always_ff @(posedge clk) begin
    if (accept) begin
      regs.u  <= div_red;
      regs.v  <= Prime;
      regs.x1 <= num_red;
      regs.x2 <= '0;
    end else if (state == ST_RUN) begin
      regs <= step_nxt;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (accept && div_zero) begin
      quotient       <= '0;
      not_invertible <= 1'b1;
    end else if ((state == ST_RUN) && step_fin) begin
      quotient       <= step_quo;
      not_invertible <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  // While running, neither remainder can reach zero before one reaches one.
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (regs.u != '0) && (regs.v != '0))
    else $error("remainder reached zero during inversion");

  // Coefficients stay reduced below the prime.
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (regs.x1 < Prime) && (regs.x2 < Prime))
    else $error("coefficient not reduced");

  // A result is delivered only once the block is idle again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Every delivered quotient is a residue, and zero when flagged.
  a_result: assert property (@(posedge clk) disable iff (rst)
    done |-> (quotient < Prime) && (!not_invertible || (quotient == '0)))
    else $error("bad result value");

  // The run ends with a strobe on the next cycle.
  a_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && step_fin |=> done)
    else $error("missing result strobe");
`endif

endmodule

### bench/testbench.sv
module testbench;
  import mdp_pkg::*;

  // Prime widened for the 64-bit arithmetic of the predictor.
  localparam longint unsigned PrimeWide = 64'(Prime);
  localparam logic [ResWidth-1:0] AllOnes = '1;
  localparam int unsigned MaxReports = 10;
  // Longest run of the inversion loop, with some margin.
  localparam int unsigned SettleCycles = 200;

  typedef struct packed {
    logic [ResWidth-1:0] quotient;
    logic                not_invertible;
  } division_result_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [ResWidth-1:0] divisor;
  logic [ResWidth-1:0] numerator;
  logic                done;
  logic [ResWidth-1:0] quotient;
  logic                not_invertible;

  division_result_t pending_quotients[$];
  int unsigned      error_count = 0;

  modular_division_prime u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .divisor        (divisor),
    .numerator      (numerator),
    .done           (done),
    .quotient       (quotient),
    .not_invertible (not_invertible)
  );

  // Free-running clock, period 10.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected result of one division: both operands are reduced modulo the
  // prime, then the inverse comes from extended Euclid on (prime, divisor).
  function automatic division_result_t predict_quotient(
    input logic [ResWidth-1:0] d_in,
    input logic [ResWidth-1:0] n_in
  );
    longint unsigned  d;
    longint unsigned  n;
    longint unsigned  r_prev;
    longint unsigned  r_cur;
    longint unsigned  r_next;
    longint unsigned  t_prev;
    longint unsigned  t_cur;
    longint unsigned  t_next;
    longint unsigned  q;
    division_result_t res;
    d = 64'(d_in) % PrimeWide;
    n = 64'(n_in) % PrimeWide;
    if (d == 0) begin
      res.quotient       = '0;
      res.not_invertible = 1'b1;
      return res;
    end
    r_prev = PrimeWide;
    r_cur  = d;
    t_prev = 0;
    t_cur  = 1;
    while (r_cur != 0) begin
      q      = r_prev / r_cur;
      r_next = r_prev - q * r_cur;
      t_next = (t_prev + PrimeWide - ((q % PrimeWide) * t_cur) % PrimeWide) % PrimeWide;
      r_prev = r_cur;
      r_cur  = r_next;
      t_prev = t_cur;
      t_cur  = t_next;
    end
    res.quotient       = ResWidth'((n * t_prev) % PrimeWide);
    res.not_invertible = 1'b0;
    return res;
  endfunction

  // Counts a failure; only the first few are printed.
  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= MaxReports) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // Every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    division_result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_quotients.size() == 0) begin
        note_failure($sformatf("unexpected result quotient=%0d not_invertible=%0b",
                               quotient, not_invertible));
      end else begin
        want = pending_quotients.pop_front();
        if (quotient !== want.quotient) begin
          note_failure($sformatf("quotient mismatch: expected %0d, got %0d",
                                 want.quotient, quotient));
        end
        if (not_invertible !== want.not_invertible) begin
          note_failure($sformatf("not_invertible mismatch: expected %0b, got %0b",
                                 want.not_invertible, not_invertible));
        end
      end
    end
  end

  // Offers one item and holds it until the block takes it.
  task automatic send_item(input logic [ResWidth-1:0] d, input logic [ResWidth-1:0] n);
    start     <= 1'b1;
    divisor   <= d;
    numerator <= n;
    do @(posedge clk); while (busy !== 1'b0);
    pending_quotients.push_back(predict_quotient(d, n));
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  task automatic idle_for(input int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic send_with_gap(input logic [ResWidth-1:0] d, input logic [ResWidth-1:0] n);
    send_item(d, n);
    idle_for(pick_gap());
  endtask

  // Holds off the sender until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_quotients.size() != 0) @(posedge clk);
  endtask

  // Field extremes, values at and above the prime, and trivial inverses.
  task automatic test_extremes();
    send_with_gap('0, '0);
    send_with_gap('0, Prime - 1);
    send_with_gap('0, AllOnes);
    send_with_gap(Prime, 30'd12345);
    send_with_gap(30'd1, '0);
    send_with_gap(30'd1, Prime - 1);
    send_with_gap(Prime - 1, 30'd1);
    send_with_gap(Prime - 1, Prime - 1);
    send_with_gap(30'd2, 30'd1);
    send_with_gap(30'd3, Prime - 1);
    send_with_gap(AllOnes, AllOnes);
    send_with_gap(AllOnes, '0);
    send_with_gap(Prime + 1, Prime);
    send_with_gap(Prime - 2, 30'd5);
    send_with_gap(30'd12345, 30'd12345);
    send_with_gap(30'h2000_0000, 30'd1);
    send_with_gap(30'h1555_5555, 30'h2AAA_AAAA);
    drain_results();
  endtask

  // Zero divisors, written as zero and as the prime itself, mixed with
  // ordinary items so the short path follows both short and long runs.
  task automatic test_zero_divisor();
    logic [ResWidth-1:0] d;
    for (int i = 0; i < 30; i++) begin
      case ($urandom_range(0, 2))
        0: d = '0;
        1: d = Prime;
        default: d = ResWidth'($urandom_range(1, Prime - 1));
      endcase
      if (i % 4 == 0) begin
        send_with_gap(d, ResWidth'($urandom));
      end else begin
        send_item(d, ResWidth'($urandom));
      end
    end
    drain_results();
  endtask

  // Random operands with a new item offered as soon as the last is taken.
  task automatic test_back_to_back();
    for (int i = 0; i < 60; i++) begin
      send_item(ResWidth'($urandom_range(0, Prime - 1)), ResWidth'($urandom_range(0, Prime - 1)));
    end
    drain_results();
  endtask

  // Bulk random stimulus, mostly in-range residues with the odd outlier.
  task automatic test_random_operands();
    logic [ResWidth-1:0] d;
    logic [ResWidth-1:0] n;
    int unsigned         roll;
    for (int i = 0; i < 1050; i++) begin
      roll = $urandom_range(0, 99);
      n    = ResWidth'($urandom_range(0, Prime - 1));
      if (roll < 72) begin
        d = ResWidth'($urandom_range(1, Prime - 1));
      end else if (roll < 84) begin
        d = ResWidth'($urandom);
        n = ResWidth'($urandom);
      end else if (roll < 90) begin
        d = ResWidth'($urandom_range(1, 16));
      end else if (roll < 95) begin
        d = ResWidth'($urandom_range(Prime - 16, AllOnes));
      end else begin
        d = ($urandom_range(0, 1) != 0) ? Prime : '0;
      end
      send_with_gap(d, n);
      // Let the block fall fully idle now and then.
      if (i % 300 == 299) drain_results();
    end
    drain_results();
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    divisor   = '0;
    numerator = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_zero_divisor();
    test_back_to_back();
    test_random_operands();

    // Allow any stray result to show up before the verdict.
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0 && pending_quotients.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
